FILE: hdl/swmm_pkg.sv
// Shared types and constants for the windowed minimum / maximum / mean block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package swmm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WINDOW  = 1024;
    localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CFG_BITS    = 16;
    localparam int RES_BITS    = 16;
    localparam int MV_BITS     = SAMPLE_BITS + CFG_BITS;
    localparam int DIV_BITS    = MV_BITS + CFG_BITS;
    localparam int STEP_BITS   = $clog2(DIV_BITS);
    localparam int INDEX_BITS  = 3;

    localparam logic [INDEX_BITS-1:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_VREF_MV       = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_FULL_SCALE    = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_CAL_SCALE     = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_CAL_OFFSET    = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_CAL_DIVISOR   = 3'd5;

    typedef struct packed {
        logic [COUNT_BITS-1:0] window_length;
        logic [CFG_BITS-1:0]   vref_mv;
        logic [CFG_BITS-1:0]   full_scale;
        logic [CFG_BITS-1:0]   cal_scale;
        logic [CFG_BITS-1:0]   cal_offset;
        logic [CFG_BITS-1:0]   cal_divisor;
    } cfg_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [COUNT_BITS-1:0]  count;
        logic [SAMPLE_BITS-1:0] min;
        logic [SAMPLE_BITS-1:0] max;
    } window_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [CFG_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/swmm_front.sv
// Front end: accumulates sum, minimum, maximum and count of each window.
// Uses swmm_pkg; hands each closed window to the queue.
`default_nettype none

module swmm_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [swmm_pkg::COUNT_BITS-1:0]  window_length,
    input  wire logic                             sample_valid,
    input  wire logic [swmm_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                  push,
    output swmm_pkg::window_t                     push_data
);

    logic [swmm_pkg::SUM_BITS-1:0]    sum_reg, sum_next;
    logic [swmm_pkg::SAMPLE_BITS-1:0] min_reg, min_next;
    logic [swmm_pkg::SAMPLE_BITS-1:0] max_reg, max_next;
    logic [swmm_pkg::COUNT_BITS-1:0]  seen_reg, seen_next;
    logic [swmm_pkg::COUNT_BITS-1:0]  len_eff;
    logic                             close;

    always_comb
    begin
        if (window_length == '0)
            len_eff = swmm_pkg::COUNT_BITS'(1);
        else if (window_length > swmm_pkg::COUNT_BITS'(swmm_pkg::MAX_WINDOW))
            len_eff = swmm_pkg::COUNT_BITS'(swmm_pkg::MAX_WINDOW);
        else
            len_eff = window_length;
    end

    always_comb
    begin
        sum_next  = sum_reg + swmm_pkg::SUM_BITS'(sample);
        min_next  = (sample < min_reg) ? sample : min_reg;
        max_next  = (sample > max_reg) ? sample : max_reg;
        seen_next = seen_reg + 1'b1;
        close     = seen_next >= len_eff;
    end

    assign push      = sample_valid && close;
    assign push_data = '{sum: sum_next, count: seen_next, min: min_next, max: max_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            seen_reg <= '0;
        end
        else if (sample_valid)
        begin
            if (close)
            begin
                sum_reg  <= '0;
                min_reg  <= '1;
                max_reg  <= '0;
                seen_reg <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                seen_reg <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swmm_queue.sv
// Two-entry queue of closed windows between the front and back ends.
// Uses swmm_pkg for the window type.
`default_nettype none

module swmm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire swmm_pkg::window_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output swmm_pkg::window_t      head
);

    swmm_pkg::window_t entry_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swmm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Uses swmm_pkg for the request and response types.
`default_nettype none

module swmm_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swmm_pkg::div_req_t req,
    output swmm_pkg::div_rsp_t      rsp
);

    logic [swmm_pkg::CFG_BITS-1:0]  rem_reg;
    logic [swmm_pkg::DIV_BITS-1:0]  quo_reg;
    logic [swmm_pkg::CFG_BITS-1:0]  divisor_reg;
    logic [swmm_pkg::STEP_BITS-1:0] step_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [swmm_pkg::CFG_BITS:0]    trial;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[swmm_pkg::DIV_BITS-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    assign rsp = '{done: done_reg, quotient: quo_reg};

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? swmm_pkg::CFG_BITS'(trial - {1'b0, divisor_reg})
                            : trial[swmm_pkg::CFG_BITS-1:0];
            quo_reg <= {quo_reg[swmm_pkg::DIV_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == swmm_pkg::STEP_BITS'(swmm_pkg::DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swmm_back.sv
// Back end: divides out the mean, scales to millivolts and calibrates the three
// results through one shared divider. Uses swmm_pkg and swmm_div.
`default_nettype none

module swmm_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire swmm_pkg::cfg_t               cfg,
    input  wire logic                         win_valid,
    input  wire swmm_pkg::window_t            win,
    output logic                              win_pop,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [3*swmm_pkg::RES_BITS-1:0]   res_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MEAN_GO   = 4'd1;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd2;
    localparam logic [3:0] ST_MUL1      = 4'd3;
    localparam logic [3:0] ST_MV_GO     = 4'd4;
    localparam logic [3:0] ST_MV_WAIT   = 4'd5;
    localparam logic [3:0] ST_MUL2      = 4'd6;
    localparam logic [3:0] ST_CHECK     = 4'd7;
    localparam logic [3:0] ST_CAL_GO    = 4'd8;
    localparam logic [3:0] ST_CAL_WAIT  = 4'd9;
    localparam logic [3:0] ST_NEXT      = 4'd10;
    localparam logic [3:0] ST_OUT       = 4'd11;

    localparam logic [1:0] SEL_MEAN = 2'd0;
    localparam logic [1:0] SEL_MIN  = 2'd1;
    localparam logic [1:0] SEL_MAX  = 2'd2;

    localparam int RB = swmm_pkg::RES_BITS;

    logic [3:0]                       state_reg;
    logic [1:0]                       sel_reg;
    swmm_pkg::window_t                win_reg;
    logic [swmm_pkg::SAMPLE_BITS-1:0] mean_reg;
    logic [swmm_pkg::DIV_BITS-1:0]    prod_reg;
    logic [swmm_pkg::MV_BITS-1:0]     mv_reg;
    logic [RB-1:0]                    mean_mv_reg, min_mv_reg, max_mv_reg;
    logic [3*RB-1:0]                  out_reg;
    logic                             out_valid_reg;
    logic [RB-1:0]                    res_value;
    logic                             res_write;
    logic [swmm_pkg::SAMPLE_BITS-1:0] stat;
    logic [swmm_pkg::CFG_BITS-1:0]    fs_eff, div_eff;
    logic                             below_offset;
    logic                             out_free;
    swmm_pkg::div_req_t               req;
    swmm_pkg::div_rsp_t               rsp;

    swmm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign fs_eff  = (cfg.full_scale == '0) ? swmm_pkg::CFG_BITS'(1) : cfg.full_scale;
    assign div_eff = (cfg.cal_divisor == '0) ? swmm_pkg::CFG_BITS'(1) : cfg.cal_divisor;
    assign below_offset = prod_reg < swmm_pkg::DIV_BITS'(cfg.cal_offset);
    assign out_free     = !out_valid_reg || res_ready;
    assign win_pop      = (state_reg == ST_IDLE) && win_valid;
    assign res_valid    = out_valid_reg;
    assign res_data     = out_reg;

    always_comb
    begin
        case (sel_reg)
            SEL_MEAN: stat = mean_reg;
            SEL_MIN:  stat = win_reg.min;
            default:  stat = win_reg.max;
        endcase
    end

    always_comb
    begin
        req.start    = 1'b0;
        req.dividend = prod_reg;
        req.divisor  = fs_eff;
        unique case (state_reg)
            ST_MEAN_GO:
            begin
                req.start    = 1'b1;
                req.dividend = swmm_pkg::DIV_BITS'(win_reg.sum);
                req.divisor  = swmm_pkg::CFG_BITS'(win_reg.count);
            end
            ST_MV_GO:
            begin
                req.start = 1'b1;
            end
            ST_CAL_GO:
            begin
                req.start   = 1'b1;
                req.divisor = div_eff;
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_write = 1'b0;
        res_value = '0;
        if (state_reg == ST_CHECK && ((sel_reg == SEL_MIN && mv_reg == '0) || below_offset))
            res_write = 1'b1;
        else if (state_reg == ST_CAL_WAIT && rsp.done)
        begin
            res_write = 1'b1;
            res_value = (rsp.quotient[swmm_pkg::DIV_BITS-1:RB] != '0) ? '1
                                                                     : rsp.quotient[RB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_pop)
            win_reg <= win;
        if (state_reg == ST_MEAN_WAIT && rsp.done)
            mean_reg <= rsp.quotient[swmm_pkg::SAMPLE_BITS-1:0];
        if (state_reg == ST_MUL1)
            prod_reg <= swmm_pkg::DIV_BITS'(swmm_pkg::MV_BITS'(stat)
                                            * swmm_pkg::MV_BITS'(cfg.vref_mv));
        else if (state_reg == ST_MUL2)
            prod_reg <= swmm_pkg::DIV_BITS'(cfg.cal_scale) * swmm_pkg::DIV_BITS'(mv_reg);
        else if (state_reg == ST_CHECK)
            prod_reg <= prod_reg - swmm_pkg::DIV_BITS'(cfg.cal_offset);
        if (state_reg == ST_MV_WAIT && rsp.done)
            mv_reg <= rsp.quotient[swmm_pkg::MV_BITS-1:0];
        if (res_write)
        begin
            case (sel_reg)
                SEL_MEAN: mean_mv_reg <= res_value;
                SEL_MIN:  min_mv_reg  <= res_value;
                default:  max_mv_reg  <= res_value;
            endcase
        end
        if (state_reg == ST_OUT && out_free)
            out_reg <= {max_mv_reg, min_mv_reg, mean_mv_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_MEAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (win_valid)
                        state_reg <= ST_MEAN_GO;
                end
                ST_MEAN_GO:
                begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (rsp.done)
                    begin
                        sel_reg   <= SEL_MEAN;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    state_reg <= ST_MV_GO;
                end
                ST_MV_GO:
                begin
                    state_reg <= ST_MV_WAIT;
                end
                ST_MV_WAIT:
                begin
                    if (rsp.done)
                        state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    state_reg <= res_write ? ST_NEXT : ST_CAL_GO;
                end
                ST_CAL_GO:
                begin
                    state_reg <= ST_CAL_WAIT;
                end
                ST_CAL_WAIT:
                begin
                    if (rsp.done)
                        state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (sel_reg == SEL_MAX)
                        state_reg <= ST_OUT;
                    else
                    begin
                        sel_reg   <= sel_reg + 2'd1;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sample_window_min_max_mean.sv
// Top level of the windowed minimum / maximum / mean block with calibration.
// Uses swmm_pkg, swmm_front, swmm_queue and swmm_back.
//
// Samples are taken one per cycle while the queue has room; the front end
// folds each into the running sum, minimum, maximum and count, and the sample
// that completes a window passes the window's statistics into a two-entry queue.
// The back end turns each window into one result transaction (mean, minimum and
// maximum in calibrated millivolts) through up to seven 44-step divisions on its
// single shared radix-2 divider. Two closed windows can wait in the queue, a third
// in the back end and one result in the output register before sample input stalls.
`default_nettype none

module sample_window_min_max_mean (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [11:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [15:0] mean_mv, [31:16] min_mv, [47:32] max_mv
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    swmm_pkg::cfg_t    cfg_reg;
    swmm_pkg::window_t push_data;
    swmm_pkg::window_t head;
    logic              push, pop, full, not_empty, sample_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= swmm_pkg::COUNT_BITS'(20);
            cfg_reg.vref_mv       <= 16'd3300;
            cfg_reg.full_scale    <= 16'd4095;
            cfg_reg.cal_scale     <= 16'd1000;
            cfg_reg.cal_offset    <= 16'd0;
            cfg_reg.cal_divisor   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swmm_pkg::REG_WINDOW_LENGTH:
                    cfg_reg.window_length <= cfg_wdata[swmm_pkg::COUNT_BITS-1:0];
                swmm_pkg::REG_VREF_MV:     cfg_reg.vref_mv     <= cfg_wdata;
                swmm_pkg::REG_FULL_SCALE:  cfg_reg.full_scale  <= cfg_wdata;
                swmm_pkg::REG_CAL_SCALE:   cfg_reg.cal_scale   <= cfg_wdata;
                swmm_pkg::REG_CAL_OFFSET:  cfg_reg.cal_offset  <= cfg_wdata;
                swmm_pkg::REG_CAL_DIVISOR: cfg_reg.cal_divisor <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign sample_valid  = s_axis_tvalid && !full;

    swmm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (cfg_reg.window_length),
        .sample_valid  (sample_valid),
        .sample        (s_axis_tdata[swmm_pkg::SAMPLE_BITS-1:0]),
        .push          (push),
        .push_data     (push_data)
    );

    swmm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    swmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .win_valid (not_empty),
        .win       (head),
        .win_pop   (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for sample_window_min_max_mean: stimulus table, then random windows.
// Depends on swmm_pkg and the block's RTL; expected windows come from a predictor held here.
`default_nettype none

module tb;

    localparam logic [swmm_pkg::INDEX_BITS-1:0] REG_SPARE = 3'd7;
    localparam int DRAIN_CYCLES   = 400;
    localparam int IDLE_LIMIT     = 5000;
    localparam int OVER_MAX_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 580;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [swmm_pkg::INDEX_BITS-1:0] idx;
        logic [15:0]                     data;
        logic                            typed;
        logic [swmm_pkg::RES_BITS-1:0]   exp_val;
    } row_t;

    typedef struct packed {
        logic [swmm_pkg::RES_BITS-1:0] max_mv;
        logic [swmm_pkg::RES_BITS-1:0] min_mv;
        logic [swmm_pkg::RES_BITS-1:0] mean_mv;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    swmm_pkg::cfg_t cfg_shadow = '{window_length: 20, vref_mv: 3300, full_scale: 4095,
                                   cal_scale: 1000, cal_offset: 0, cal_divisor: 1000};
    swmm_pkg::window_t win_acc = '{sum: '0, count: '0, min: '1, max: '0};

    result_t     pending_results [$];
    int unsigned error_count = 0;
    int unsigned windows_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    bit          window_dirty = 1'b0;
    logic [10:0] stall_phase = '0;

    sample_window_min_max_mean u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [swmm_pkg::RES_BITS-1:0] calibrated_mv(input longint unsigned x,
                                                                    input bit zero_kept);
        longint unsigned fs;
        longint unsigned dv;
        longint unsigned mv;
        longint unsigned prod;
        longint unsigned q;
        fs = (cfg_shadow.full_scale == 0) ? 64'd1 : 64'(cfg_shadow.full_scale);
        dv = (cfg_shadow.cal_divisor == 0) ? 64'd1 : 64'(cfg_shadow.cal_divisor);
        mv = (x * 64'(cfg_shadow.vref_mv)) / fs;
        if (zero_kept && mv == 0)
            return '0;
        prod = 64'(cfg_shadow.cal_scale) * mv;
        if (prod < 64'(cfg_shadow.cal_offset))
            return '0;
        q = (prod - 64'(cfg_shadow.cal_offset)) / dv;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic bit fold_sample(input logic [15:0] word, output result_t r);
        logic [swmm_pkg::SAMPLE_BITS-1:0] s;
        int unsigned len;
        s = word[swmm_pkg::SAMPLE_BITS-1:0];
        len = cfg_shadow.window_length;
        if (len == 0)
            len = 1;
        if (len > swmm_pkg::MAX_WINDOW)
            len = swmm_pkg::MAX_WINDOW;
        win_acc.sum = win_acc.sum + swmm_pkg::SUM_BITS'(s);
        if (s < win_acc.min)
            win_acc.min = s;
        if (s > win_acc.max)
            win_acc.max = s;
        win_acc.count = win_acc.count + 1'b1;
        if (win_acc.count < len)
            return 1'b0;
        r.mean_mv = calibrated_mv(64'(win_acc.sum) / 64'(win_acc.count), 1'b0);
        r.min_mv  = calibrated_mv(64'(win_acc.min), 1'b1);
        r.max_mv  = calibrated_mv(64'(win_acc.max), 1'b0);
        win_acc = '{sum: '0, count: '0, min: '1, max: '0};
        return 1'b1;
    endfunction

    function automatic void apply_cfg(input logic [swmm_pkg::INDEX_BITS-1:0] idx,
                                      input logic [15:0] data);
        case (idx)
            swmm_pkg::REG_WINDOW_LENGTH:
                cfg_shadow.window_length = data[swmm_pkg::COUNT_BITS-1:0];
            swmm_pkg::REG_VREF_MV:     cfg_shadow.vref_mv = data;
            swmm_pkg::REG_FULL_SCALE:  cfg_shadow.full_scale = data;
            swmm_pkg::REG_CAL_SCALE:   cfg_shadow.cal_scale = data;
            swmm_pkg::REG_CAL_OFFSET:  cfg_shadow.cal_offset = data;
            swmm_pkg::REG_CAL_DIVISOR: cfg_shadow.cal_divisor = data;
            default:                   ;
        endcase
    endfunction

    function automatic logic [15:0] pick_setting(input logic [15:0] typical);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            5:       return 16'($urandom);
            default: return typical;
        endcase
    endfunction

    function automatic logic [swmm_pkg::SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return swmm_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic cfg_write(input logic [swmm_pkg::INDEX_BITS-1:0] idx,
                             input logic [15:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        if (window_dirty)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            window_dirty = 1'b0;
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_cfg(idx, data);
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] word, input bit typed, input result_t typed_r);
        result_t r;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
        window_dirty = 1'b1;
        if (fold_sample(word, r))
            pending_results.push_back(typed ? typed_r : r);
    endtask

    // Result side: checks every transaction and keeps the watchdog's idle count.
    always @(posedge clk)
    begin
        result_t want;
        string   field_names [3];
        field_names = '{"mean_mv", "min_mv", "max_mv"};
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("result %h with no window pending", m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                for (int i = 0; i < 3; i++)
                    if (m_axis_tdata[16*i +: 16] !== want[16*i +: 16])
                        flag_error($sformatf("window %0d %s: got %0d, expected %0d",
                                             windows_checked, field_names[i],
                                             m_axis_tdata[16*i +: 16], want[16*i +: 16]));
                windows_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[10:9])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= (stall_phase[4:0] >= 5'd24);
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    initial
    begin
        do
            @(posedge clk);
        while (idle_cycles < IDLE_LIMIT);
        $display("Watchdog: no transaction for %0d cycles, %0d windows outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        row_t        plan [$];
        result_t     typed_r;
        int unsigned directed_count;
        int unsigned random_sent;
        int unsigned wlen;
        logic [15:0] wdata;
        int unsigned n;

        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'd1,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd0,    1'b1, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b1, 16'd3300});
        plan.push_back('{ROW_SAMPLE, '0,                          16'hF800, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'h0FFF, 1'b1, 16'd3300});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd1,    1'b1, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_OFFSET,    16'hFFFF, 1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd1,    1'b1, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_VREF_MV,       16'hFFFF, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_FULL_SCALE,    16'd1,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_SCALE,     16'hFFFF, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_OFFSET,    16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_DIVISOR,   16'd1,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b1, 16'hFFFF});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd0,    1'b1, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_VREF_MV,       16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b1, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_VREF_MV,       16'd1,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_FULL_SCALE,    16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_SCALE,     16'd1,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_DIVISOR,   16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b1, 16'd4095});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd7,    1'b1, 16'd7});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_VREF_MV,       16'd3300, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_FULL_SCALE,    16'd4095, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_SCALE,     16'd1000, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_CAL_DIVISOR,   16'd1000, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'd4,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd100,  1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd0,    1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'd2,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd2000, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'd3,    1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd4095, 1'b1, 16'd3300});
        plan.push_back('{ROW_CFG,    REG_SPARE,                   16'hFFFF, 1'b0, 16'd0});
        plan.push_back('{ROW_CFG,    swmm_pkg::REG_WINDOW_LENGTH, 16'hF802, 1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd10,   1'b0, 16'd0});
        plan.push_back('{ROW_SAMPLE, '0,                          16'd20,   1'b0, 16'd0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                cfg_write(plan[i].idx, plan[i].data);
            else
            begin
                typed_r = '{max_mv: plan[i].exp_val, min_mv: plan[i].exp_val,
                            mean_mv: plan[i].exp_val};
                send_sample(plan[i].data, plan[i].typed, typed_r);
            end
        end
        directed_count = samples_sent;

        // The length register is written beyond the maximum and is clamped to 1024, so the
        // window stays open until the length is lowered; the next sample then closes it.
        cfg_write(swmm_pkg::REG_WINDOW_LENGTH, 16'h07FF);
        cfg_write(swmm_pkg::REG_VREF_MV, pick_setting(16'd3300));
        cfg_write(swmm_pkg::REG_FULL_SCALE, pick_setting(16'd4095));
        cfg_write(swmm_pkg::REG_CAL_SCALE, pick_setting(16'd1000));
        cfg_write(swmm_pkg::REG_CAL_OFFSET, 16'd0);
        cfg_write(swmm_pkg::REG_CAL_DIVISOR, pick_setting(16'd1000));
        repeat (OVER_MAX_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
                send_sample(16'(12'd4095 - 12'($urandom_range(0, 15))), 1'b0, '0);
            else
                send_sample(16'(random_sample()), 1'b0, '0);
        end
        cfg_write(swmm_pkg::REG_WINDOW_LENGTH, 16'd5);
        send_sample(16'(random_sample()), 1'b0, '0);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       wlen = 0;
                1:       wlen = $urandom_range(40, 150);
                default: wlen = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 4) == 0)
                wdata = {5'($urandom), 11'(wlen)};
            else
                wdata = 16'(wlen);
            cfg_write(swmm_pkg::REG_WINDOW_LENGTH, wdata);
            if ($urandom_range(0, 1) == 0)
                cfg_write(swmm_pkg::REG_VREF_MV, pick_setting(16'd3300));
            if ($urandom_range(0, 1) == 0)
                cfg_write(swmm_pkg::REG_FULL_SCALE, pick_setting(16'd4095));
            if ($urandom_range(0, 1) == 0)
                cfg_write(swmm_pkg::REG_CAL_SCALE, pick_setting(16'd1000));
            if ($urandom_range(0, 1) == 0)
                cfg_write(swmm_pkg::REG_CAL_OFFSET,
                          pick_setting(16'($urandom_range(0, 2000))));
            if ($urandom_range(0, 1) == 0)
                cfg_write(swmm_pkg::REG_CAL_DIVISOR, pick_setting(16'd1000));
            n = (wlen > 12) ? wlen + $urandom_range(0, 8) : $urandom_range(1, 40);
            repeat (n)
            begin
                send_sample(16'(random_sample()), 1'b0, '0);
                random_sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d from the table) across %0d register writes.",
                 samples_sent, directed_count, cfg_writes);
        $display("Compared %0d window results under sender gaps and receiver stalls.",
                 windows_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
